[hw/rtl/linked_list_queue_manager_defines.svh]
// Assertion helpers for the queue manager checker.
// Both sample on clk and are quiet while rst is high.
`ifndef LINKED_LIST_QUEUE_MANAGER_DEFINES_SVH
`define LINKED_LIST_QUEUE_MANAGER_DEFINES_SVH

// Same-cycle implication.
`define LLQM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LLQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/llqm_pkg.sv]
package llqm_pkg;

  // Operation codes carried on the action input.
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_INIT,    // link memory initialization sweep
    ST_IDLE,    // waiting for a command
    ST_LOOK,    // queue pointers and free-list link are available
    ST_FINISH   // second memory step of a dequeue or a tail relink
  } state_t;

endpackage

[hw/rtl/llqm_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module llqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/linked_list_queue_manager.sv]
// Linked-list queue manager: QUEUE_COUNT FIFO queues share one pool of
// POOL_ENTRIES entries. Each queue is a chain through a link memory; unused
// entries sit on a free list used as a stack. A command is transferred when
// start is high and busy is low. Exactly one result follows each command,
// shown for a single cycle with done high; the receiver cannot stall it, so
// it must take ok, data_out, queue_empty and pool_empty in that cycle.
// Timing is set by the registered read ports of the pointer and link
// memories. After the transfer, a failed command or an enqueue to an empty
// queue is decided in ST_LOOK; an enqueue to a non-empty queue also puts out
// its result there and relinks the old tail in ST_FINISH, behind the result;
// a dequeue reads the head pointer, then link and data, ending in ST_FINISH.
// The result appears the cycle after its last deciding cycle; after a failed
// command, an enqueue to an empty queue or a dequeue, a new command may be
// transferred in that same cycle.
// After reset the block sweeps every entry of the link memory to build the
// initial free list; busy stays high during that sweep.
// A queue_id at or above QUEUE_COUNT is ignored: ok 0, queue_empty 1.
module linked_list_queue_manager #(
  parameter int POOL_ENTRIES = 64,
  parameter int QUEUE_COUNT  = 4,
  parameter int DATA_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [1:0]  queue_id,
  input  logic [31:0] data_in,
  // result side
  output logic        done,
  output logic        ok,
  output logic [31:0] data_out,
  output logic        queue_empty,
  output logic        pool_empty
);

  localparam int AW = $clog2(POOL_ENTRIES);                        // entry index
  localparam int CW = $clog2(POOL_ENTRIES + 1);                    // free count
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1; // queue index

  llqm_pkg::state_t state, state_next;

  // command latched at transfer
  logic                 act_r;
  logic [QW-1:0]        qidx_r;
  logic                 qvalid_r;
  logic [DATA_BITS-1:0] data_r;

  // free list and queue status
  logic [AW-1:0]          free_head, free_head_next;
  logic [CW-1:0]          free_count, free_count_next;
  logic [QUEUE_COUNT-1:0] flags, flags_next;
  logic [AW-1:0]          clr_idx;
  logic [AW-1:0]          ent_r, ent_next;   // entry taken by a tail-linking enqueue

  // memory ports
  logic                 link_we, link_re;
  logic [AW-1:0]        link_waddr, link_raddr, link_wdata, link_rd;
  logic                 item_we, item_re;
  logic [AW-1:0]        item_addr;
  logic [DATA_BITS-1:0] item_rd;
  logic                 head_we, head_re, tail_we, tail_re;
  logic [AW-1:0]        head_wdata, tail_wdata, head_rd, tail_rd;

  // result values
  logic        res_valid, res_ok, res_qempty, res_pempty;
  logic [31:0] res_data;

  logic accept;
  logic [QW-1:0] qidx_in;
  logic nonempty, is_enq, enq_ok;

  assign accept   = start && !busy;
  assign qidx_in  = QW'(queue_id);
  assign busy     = (state != llqm_pkg::ST_IDLE);
  assign is_enq   = (act_r == llqm_pkg::ACT_ENQUEUE);
  assign nonempty = qvalid_r && flags[qidx_r];
  assign enq_ok   = qvalid_r && (free_count != '0);

  // State memories: link chain, data words, per-queue head and tail.
  llqm_ram #(.WIDTH(AW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (link_re),
    .raddr(link_raddr),
    .rdata(link_rd)
  );

  llqm_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_ENTRIES)) u_item_ram (
    .clk  (clk),
    .we   (item_we),
    .waddr(item_addr),
    .wdata(data_r),
    .re   (item_re),
    .raddr(item_addr),
    .rdata(item_rd)
  );

  llqm_ram #(.WIDTH(AW), .DEPTH(QUEUE_COUNT)) u_head_ram (
    .clk  (clk),
    .we   (head_we),
    .waddr(qidx_r),
    .wdata(head_wdata),
    .re   (head_re),
    .raddr(qidx_in),
    .rdata(head_rd)
  );

  llqm_ram #(.WIDTH(AW), .DEPTH(QUEUE_COUNT)) u_tail_ram (
    .clk  (clk),
    .we   (tail_we),
    .waddr(qidx_r),
    .wdata(tail_wdata),
    .re   (tail_re),
    .raddr(qidx_in),
    .rdata(tail_rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      llqm_pkg::ST_INIT: begin
        if (clr_idx == AW'(POOL_ENTRIES - 1)) begin
          state_next = llqm_pkg::ST_IDLE;
        end
      end
      llqm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = llqm_pkg::ST_LOOK;
        end
      end
      llqm_pkg::ST_LOOK: begin
        if (is_enq) begin
          state_next = (enq_ok && nonempty) ? llqm_pkg::ST_FINISH : llqm_pkg::ST_IDLE;
        end else begin
          state_next = nonempty ? llqm_pkg::ST_FINISH : llqm_pkg::ST_IDLE;
        end
      end
      llqm_pkg::ST_FINISH: begin
        state_next = llqm_pkg::ST_IDLE;
      end
      default: begin
        state_next = llqm_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory controls, pointer updates and result.
  always_comb begin
    link_we         = 1'b0;
    link_waddr      = free_head;
    link_wdata      = '0;
    link_re         = 1'b0;
    link_raddr      = free_head;
    item_we         = 1'b0;
    item_re         = 1'b0;
    item_addr       = free_head;
    head_we         = 1'b0;
    head_wdata      = free_head;
    head_re         = 1'b0;
    tail_we         = 1'b0;
    tail_wdata      = free_head;
    tail_re         = 1'b0;
    free_head_next  = free_head;
    free_count_next = free_count;
    flags_next      = flags;
    ent_next        = ent_r;
    res_valid       = 1'b0;
    res_ok          = 1'b0;
    res_data        = '0;
    res_qempty      = !nonempty;
    res_pempty      = (free_count == '0);

    unique case (state)
      llqm_pkg::ST_INIT: begin
        link_we    = 1'b1;
        link_waddr = clr_idx;
        link_wdata = (clr_idx == '0) ? '0 : clr_idx - AW'(1);
      end
      llqm_pkg::ST_IDLE: begin
        if (start) begin
          head_re = 1'b1;
          tail_re = 1'b1;
          link_re = 1'b1;     // next free entry after free_head
        end
      end
      llqm_pkg::ST_LOOK: begin
        if (is_enq) begin
          res_valid = !nonempty || !enq_ok;
          if (enq_ok) begin
            item_we         = 1'b1;
            link_we         = 1'b1;          // new entry ends the chain
            free_head_next  = link_rd;
            free_count_next = free_count - CW'(1);
            tail_we         = 1'b1;
            ent_next        = free_head;
            if (!nonempty) begin
              head_we            = 1'b1;
              flags_next[qidx_r] = 1'b1;
            end
            // result goes out now; a tail relink finishes behind it
            res_valid  = 1'b1;
            res_ok     = 1'b1;
            res_qempty = 1'b0;
            res_pempty = (free_count == CW'(1));
          end
        end else begin
          if (nonempty) begin
            link_re    = 1'b1;
            link_raddr = head_rd;
            item_re    = 1'b1;
            item_addr  = head_rd;
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      llqm_pkg::ST_FINISH: begin
        if (is_enq) begin
          link_we    = 1'b1;
          link_waddr = tail_rd;
          link_wdata = ent_r;
        end else begin
          // head entry returns to the free stack
          link_we        = 1'b1;
          link_waddr     = head_rd;
          link_wdata     = free_head;
          free_head_next = head_rd;
          if (free_count < CW'(POOL_ENTRIES)) begin
            free_count_next = free_count + CW'(1);
          end
          if (head_rd == tail_rd) begin
            flags_next[qidx_r] = 1'b0;
          end else begin
            head_we    = 1'b1;
            head_wdata = link_rd;
          end
          res_valid  = 1'b1;
          res_ok     = 1'b1;
          res_data   = 32'(item_rd);
          res_qempty = (head_rd == tail_rd);
          res_pempty = (free_count_next == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= llqm_pkg::ST_INIT;
      clr_idx    <= '0;
      free_head  <= AW'(POOL_ENTRIES - 1);
      free_count <= CW'(POOL_ENTRIES);
      flags      <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_count <= free_count_next;
      flags      <= flags_next;
      done       <= res_valid;
      if (state == llqm_pkg::ST_INIT) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= action;
      qidx_r   <= qidx_in;
      qvalid_r <= (32'(queue_id) < QUEUE_COUNT);
      data_r   <= DATA_BITS'(data_in);
    end
    ent_r <= ent_next;
    if (res_valid) begin
      ok          <= res_ok;
      data_out    <= res_data;
      queue_empty <= res_qempty;
      pool_empty  <= res_pempty;
    end
  end

endmodule

[hw/rtl/llqm_checker.sv]
`include "linked_list_queue_manager_defines.svh"

// Port-level checks on the queue manager.
module llqm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        action,
  input logic [1:0]  queue_id,
  input logic [31:0] data_in,
  input logic        done,
  input logic        ok,
  input logic [31:0] data_out,
  input logic        queue_empty,
  input logic        pool_empty
);

  `LLQM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after transfer")

  `LLQM_ASSERT_NEXT(a_idle_no_done, !busy, !done, "result without a command")

  `LLQM_ASSERT_NOW(a_fail_zero, done && !ok, data_out == 32'd0, "failed step data")

  `LLQM_ASSERT_NOW(a_ok_status, done && ok, !(queue_empty && pool_empty), "bad status")

endmodule

bind linked_list_queue_manager llqm_checker u_llqm_checker (.*);

[tb/sv/linked_list_queue_manager_tb.sv]
`timescale 1ns / 1ps

module linked_list_queue_manager_tb;

  localparam int POOL_ENTRIES = 64;
  localparam int QUEUE_COUNT  = 4;
  localparam int DATA_BITS    = 32;
  // Generous: ~1560 commands plus long sender gaps.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  // One result as the block should report it.
  typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic        qempty;
    logic        pempty;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        action;
  logic [1:0]  queue_id;
  logic [31:0] data_in;
  logic        done;
  logic        ok;
  logic [31:0] data_out;
  logic        queue_empty;
  logic        pool_empty;

  linked_list_queue_manager #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .QUEUE_COUNT (QUEUE_COUNT),
    .DATA_BITS   (DATA_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .queue_id   (queue_id),
    .data_in    (data_in),
    .done       (done),
    .ok         (ok),
    .data_out   (data_out),
    .queue_empty(queue_empty),
    .pool_empty (pool_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the shared pool: data words, next links, free-list stack,
  // per-queue head/tail and the non-empty mask.
  logic [31:0]            item_mem  [POOL_ENTRIES];
  logic [5:0]             next_link [POOL_ENTRIES];
  logic [5:0]             free_top;
  int                     free_num;
  logic [5:0]             q_head    [QUEUE_COUNT];
  logic [5:0]             q_tail    [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] live_mask;

  reply_t pending_replies[$];
  reply_t oldest_reply;
  int     error_count = 0;
  int     cycle_count = 0;
  int     sender_idle_pct = 0;

  // Applies one command to the shadow pool and returns the result it owes.
  function automatic reply_t apply_queue_op(logic act, logic [1:0] qid,
                                            logic [31:0] din);
    reply_t     r;
    logic [5:0] slot;
    r = '0;
    r.qempty = 1'b1;
    if (int'(qid) < QUEUE_COUNT) begin
      if (act == llqm_pkg::ACT_ENQUEUE) begin
        if (free_num > 0) begin
          // pop the free stack, fill the entry, hang it off the tail
          slot = free_top;
          free_top = next_link[slot];
          free_num--;
          item_mem[slot] = din;
          next_link[slot] = '0;
          if (live_mask[qid]) begin
            next_link[q_tail[qid]] = slot;
            q_tail[qid] = slot;
          end else begin
            q_head[qid] = slot;
            q_tail[qid] = slot;
            live_mask[qid] = 1'b1;
          end
          r.ok = 1'b1;
        end
      end else if (live_mask[qid]) begin
        // unlink the head and push its entry back on the free stack
        slot = q_head[qid];
        r.data = item_mem[slot];
        if (slot == q_tail[qid]) begin
          live_mask[qid] = 1'b0;
        end else begin
          q_head[qid] = next_link[slot];
        end
        next_link[slot] = free_top;
        free_top = slot;
        if (free_num < POOL_ENTRIES) free_num++;
        r.ok = 1'b1;
      end
      r.qempty = !live_mask[qid];
    end
    r.pempty = (free_num == 0);
    return r;
  endfunction

  // Presents one command from the falling edge on, with optional sender gaps,
  // and holds it until the transfer (start high, busy low at a rising edge).
  // start is only lowered inside a gap, so back-to-back commands keep it high.
  task automatic send_op(input logic act, input logic [1:0] qid,
                         input logic [31:0] din);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    action   = act;
    queue_id = qid;
    data_in  = din;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(apply_queue_op(act, qid, din));
  endtask

  // Result checker: done is a one-cycle strobe, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with none outstanding: ok %0b data_out %h", $time,
                 ok, data_out);
        error_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (ok !== oldest_reply.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, oldest_reply.ok, ok);
          error_count++;
        end
        if (data_out !== oldest_reply.data) begin
          $display("%0t: data_out expected %h actual %h", $time,
                   oldest_reply.data, data_out);
          error_count++;
        end
        if (queue_empty !== oldest_reply.qempty) begin
          $display("%0t: queue_empty expected %0b actual %0b", $time,
                   oldest_reply.qempty, queue_empty);
          error_count++;
        end
        if (pool_empty !== oldest_reply.pempty) begin
          $display("%0t: pool_empty expected %0b actual %0b", $time,
                   oldest_reply.pempty, pool_empty);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Dequeue from every queue while all are empty: each must fail.
  task automatic test_empty_dequeue();
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      send_op(llqm_pkg::ACT_DEQUEUE, q[1:0], $urandom);
    end
  endtask

  // Data extremes and alternating patterns through every queue; FIFO order
  // within a queue, then a dequeue past the end.
  task automatic test_data_extremes();
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd0, 32'h0000_0000);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd1, 32'hFFFF_FFFF);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd2, 32'hAAAA_AAAA);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd3, 32'h5555_5555);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd0, 32'hFFFF_FFFF);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd0, 32'h0);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd0, 32'h0);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd1, 32'h0);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd2, 32'h0);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd3, 32'h0);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd0, 32'h0);
  endtask

  // Head equals tail: one-entry queue emptied by a dequeue, refilled, and
  // a neighbor queue interleaved.
  task automatic test_single_entry();
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd2, $urandom);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd2, $urandom);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd2, $urandom);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd2, $urandom);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'd1, $urandom);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd2, $urandom);
    send_op(llqm_pkg::ACT_DEQUEUE, 2'd1, $urandom);
  endtask

  // Fill the pool from random queues, enqueue into exhaustion, free one entry
  // and take it back, then drain every queue past empty.
  task automatic test_pool_full();
    logic [1:0] qid;
    while (free_num > 0) begin
      send_op(llqm_pkg::ACT_ENQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
    end
    repeat (3) begin
      send_op(llqm_pkg::ACT_ENQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
    end
    qid = 2'($urandom_range(QUEUE_COUNT - 1));
    while (!live_mask[qid]) qid = qid + 2'd1;
    send_op(llqm_pkg::ACT_DEQUEUE, qid, $urandom);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
    send_op(llqm_pkg::ACT_ENQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      while (live_mask[q]) send_op(llqm_pkg::ACT_DEQUEUE, q[1:0], $urandom);
      send_op(llqm_pkg::ACT_DEQUEUE, q[1:0], $urandom);
    end
  endtask

  // Random traffic in blocks of 50 with a drifting enqueue bias, so the pool
  // swings between full and drained; sender gap rate changes per phase.
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    int enq_pct;
    sender_idle_pct = idle_pct;
    enq_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      if ($urandom_range(99) < enq_pct) begin
        send_op(llqm_pkg::ACT_ENQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
      end else begin
        send_op(llqm_pkg::ACT_DEQUEUE, 2'($urandom_range(QUEUE_COUNT - 1)), $urandom);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    action   = llqm_pkg::ACT_ENQUEUE;
    queue_id = '0;
    data_in  = '0;
    // shadow pool after reset: entry i links to i-1, free stack topped at
    // the highest entry
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      item_mem[i]  = '0;
      next_link[i] = (i == 0) ? 6'd0 : 6'(i - 1);
    end
    free_top = 6'(POOL_ENTRIES - 1);
    free_num = POOL_ENTRIES;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      q_head[q] = '0;
      q_tail[q] = '0;
    end
    live_mask = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // busy covers the link sweep after reset; send_op waits it out

    sender_idle_pct = 0;
    test_empty_dequeue();
    test_data_extremes();
    test_single_entry();
    sender_idle_pct = 30;
    test_pool_full();
    test_random_traffic(0, 280);
    test_random_traffic(65, 280);
    test_random_traffic(30, 280);
    test_random_traffic(0, 280);
    test_random_traffic(65, 280);

    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // catch any stray strobe after the last result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/llqm_pkg.sv
hw/rtl/llqm_ram.sv
hw/rtl/linked_list_queue_manager.sv
hw/rtl/llqm_checker.sv
tb/sv/linked_list_queue_manager_tb.sv
